@@ rtl/core/multi_channel_oneshot_timer_unit_assert.svh @@
// Assertion macros shared by the one-shot timer RTL.
`ifndef MULTI_CHANNEL_ONESHOT_TIMER_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_ONESHOT_TIMER_UNIT_ASSERT_SVH

// Clocked check, masked while reset is high.
`define MCOT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define MCOT_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/mcot_pkg.sv @@
// Types and constants for the multi-channel one-shot timer.
`default_nettype none

package mcot_pkg;

  // Request field widths
  localparam int MODE_W   = 2;
  localparam int CHAN_W   = 2;
  localparam int PERIOD_W = 32;
  localparam int SUB_W    = 14;

  // Response field widths
  localparam int MASK_W = 4;
  localparam int TIME_W = 32;

  // Microseconds per millisecond and the width of sub_count scaled by it
  localparam int US_PER_MS = 1000;
  localparam int US_W      = 10;
  localparam int SCALED_W  = SUB_W + US_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_ARM    = 2'd1,
    MODE_CANCEL = 2'd2
  } mode_t;

  // Step control from the pipeline to the state blocks
  typedef struct packed {
    logic              en;
    mode_t             mode;
    logic [CHAN_W-1:0] chan;
  } ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/mcot_if.sv @@
// Request and response channel interfaces of the one-shot timer.
`default_nettype none

interface mcot_req_if;
  import mcot_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [CHAN_W-1:0]   channel;
  logic [PERIOD_W-1:0] period;
  logic [SUB_W-1:0]    sub_count;

  modport source (output valid, mode, channel, period, sub_count, input ready);
  modport sink (input valid, mode, channel, period, sub_count, output ready);
endinterface

interface mcot_rsp_if;
  import mcot_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] fired_mask;
  logic [TIME_W-1:0] milliseconds;
  logic [TIME_W-1:0] microseconds;

  modport source (output valid, fired_mask, milliseconds, microseconds, input ready);
  modport sink (input valid, fired_mask, milliseconds, microseconds, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mcot_chan_bank.sv @@
// One-shot countdown channels: load, cancel, decrement and expiry.
`default_nettype none

`include "multi_channel_oneshot_timer_unit_assert.svh"

module mcot_chan_bank #(
  parameter int CHANNELS = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire mcot_pkg::ctl_t                 ctl,
  input  wire logic [mcot_pkg::PERIOD_W-1:0]  period,
  output logic      [CHANNELS-1:0]            fired
);
  import mcot_pkg::*;

  logic [CHANNELS-1:0] active;
  logic [CHANNELS-1:0] active_next;
  logic [PERIOD_W-1:0] remaining      [CHANNELS];
  logic [PERIOD_W-1:0] remaining_next [CHANNELS];
  logic [PERIOD_W-1:0] dec            [CHANNELS];

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic hit;

    assign hit    = (int'(ctl.chan) == c);
    assign dec[c] = remaining[c] - PERIOD_W'(1);

    // Per-channel next state
    always_comb begin
      active_next[c]    = active[c];
      remaining_next[c] = remaining[c];
      fired[c]          = 1'b0;
      if (ctl.en) begin
        case (ctl.mode)
          MODE_TICK: begin
            if (active[c]) begin
              remaining_next[c] = dec[c];
              if (dec[c] == '0) begin
                fired[c]       = 1'b1;
                active_next[c] = 1'b0;
              end
            end
          end
          MODE_ARM: begin
            if (hit) begin
              remaining_next[c] = period;
              active_next[c]    = 1'b1;
            end
          end
          MODE_CANCEL: begin
            if (hit) begin
              active_next[c] = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        active[c] <= 1'b0;
      end else begin
        active[c] <= active_next[c];
      end
    end

    // Count is only read while active, so it needs no reset
    always_ff @(posedge clk) begin
      remaining[c] <= remaining_next[c];
    end
  end

  `MCOT_CHECK(a_fire_only_on_tick, (|fired) |-> (ctl.en && ctl.mode == MODE_TICK), "fire outside a tick")
  `MCOT_CHECK(a_fire_needs_active, (fired & ~active) == '0, "inactive channel fired")
  `MCOT_CHECK(a_tick_never_arms, (ctl.en && ctl.mode == MODE_TICK) |=> $countones(active) <= $past($countones(active)), "tick raised active count")

endmodule

`default_nettype wire

@@ rtl/core/mcot_time_base.sv @@
// Millisecond counter and microsecond readout.
`default_nettype none

`include "multi_channel_oneshot_timer_unit_assert.svh"

module mcot_time_base #(
  parameter int SUBTICKS_PER_MS = 16000
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire mcot_pkg::ctl_t                 ctl,
  input  wire logic [mcot_pkg::SCALED_W-1:0]  sub_scaled,
  output logic      [mcot_pkg::TIME_W-1:0]    ms_new,
  output logic      [mcot_pkg::TIME_W-1:0]    us_new
);
  import mcot_pkg::*;

  // Round-up reciprocal: exact floor division for any SCALED_W-bit dividend
  localparam int SHIFT = SCALED_W + $clog2(SUBTICKS_PER_MS);
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(SUBTICKS_PER_MS) - 64'd1) / 64'(SUBTICKS_PER_MS);
  localparam int RECIP_W = SCALED_W + 1;
  localparam int PROD_W  = SCALED_W + RECIP_W;

  logic [TIME_W-1:0]   ms_count;
  logic [TIME_W-1:0]   ms_count_next;
  logic [RECIP_W-1:0]  recip;
  logic [PROD_W-1:0]   prod;
  logic [SCALED_W-1:0] quot;

  assign recip = RECIP_W'(RECIP);

  // Counter advance on a tick
  always_comb begin
    ms_count_next = ms_count;
    if (ctl.en && ctl.mode == MODE_TICK) begin
      ms_count_next = ms_count + TIME_W'(1);
    end
  end

  assign ms_new = ms_count_next;

  // sub_scaled / SUBTICKS_PER_MS by reciprocal multiply
  assign prod = PROD_W'(sub_scaled) * PROD_W'(recip);
  assign quot = SCALED_W'(prod >> SHIFT);

  assign us_new = ms_count_next * TIME_W'(US_PER_MS) + TIME_W'(quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_count <= '0;
    end else begin
      ms_count <= ms_count_next;
    end
  end

  `MCOT_CHECK(a_ms_holds_off_tick, !(ctl.en && ctl.mode == MODE_TICK) |=> $stable(ms_count), "ms counter moved without tick")

endmodule

`default_nettype wire

@@ rtl/core/multi_channel_oneshot_timer_unit.sv @@
// Top level of the multi-channel one-shot timer: request stage, state blocks, response stage.
//
//  channel | dir | fields
//  --------+-----+------------------------------------------------
//  req     | in  | mode, channel, period, sub_count
//  rsp     | out | fired_mask, milliseconds, microseconds
//
// Each request gives one response after the input and response registers, one per cycle unless rsp.ready stalls.
// The input register and the response register make the two pipeline stages;
// the channel decrement and reciprocal scaling sit between them.
// A stalled response holds the request stage; req.ready falls only when both are full.
// Synchronous reset clears the ms counter, channel active bits and stage valids.
`default_nettype none

`include "multi_channel_oneshot_timer_unit_assert.svh"

module multi_channel_oneshot_timer_unit #(
  parameter int CHANNELS        = 4,
  parameter int SUBTICKS_PER_MS = 16000
) (
  input wire logic  clk,
  input wire logic  rst,
  mcot_req_if.sink  req,
  mcot_rsp_if.source rsp
);
  import mcot_pkg::*;

  // Request stage
  logic                s1_valid;
  logic [MODE_W-1:0]   s1_mode;
  logic [CHAN_W-1:0]   s1_chan;
  logic [PERIOD_W-1:0] s1_period;
  logic [SCALED_W-1:0] s1_scaled;
  logic                adv;

  // Response stage
  logic                o_valid;
  logic                o_valid_next;
  logic [MASK_W-1:0]   o_mask;
  logic [TIME_W-1:0]   o_ms;
  logic [TIME_W-1:0]   o_us;

  ctl_t                ctl;
  logic [CHANNELS-1:0] fired;
  logic [MASK_W-1:0]   fired_mask;
  logic [TIME_W-1:0]   ms_new;
  logic [TIME_W-1:0]   us_new;

  assign adv       = s1_valid && (!o_valid || rsp.ready);
  assign req.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_mode   <= req.mode;
      s1_chan   <= req.channel;
      s1_period <= req.period;
      s1_scaled <= SCALED_W'(req.sub_count) * SCALED_W'(US_PER_MS);
    end
  end

  assign ctl.en   = adv;
  assign ctl.mode = mode_t'(s1_mode);
  assign ctl.chan = s1_chan;

  mcot_chan_bank #(
    .CHANNELS (CHANNELS)
  ) u_bank (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .period (s1_period),
    .fired  (fired)
  );

  mcot_time_base #(
    .SUBTICKS_PER_MS (SUBTICKS_PER_MS)
  ) u_time (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sub_scaled (s1_scaled),
    .ms_new     (ms_new),
    .us_new     (us_new)
  );

  // Only the low channels show in the mask
  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < CHANNELS) begin : g_on
      assign fired_mask[i] = fired[i];
    end else begin : g_off
      assign fired_mask[i] = 1'b0;
    end
  end

  // Response register
  assign o_valid_next = adv || (o_valid && !rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_mask <= fired_mask;
      o_ms   <= ms_new;
      o_us   <= us_new;
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.fired_mask   = o_mask;
  assign rsp.milliseconds = o_ms;
  assign rsp.microseconds = o_us;

  `MCOT_CHECK(a_ready_when_empty, !o_valid |-> req.ready, "request stalled with empty response stage")
  `MCOT_CHECK_ALWAYS(a_reset_clears_valid, rst |=> (!o_valid && !s1_valid), "valid survived reset")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the multi-channel one-shot timer unit.
`default_nettype none

module tb;
  import mcot_pkg::*;

  localparam int CHANNELS        = 4;
  localparam int SUBTICKS_PER_MS = 16000;
  localparam int RANDOM_ITEMS    = 200;   // per idling phase, four phases
  localparam int QUIET_LIMIT     = 4000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES     = 8;
  localparam int MAX_REPORTS     = 10;

  // Mode 3 has no enum member; the block must treat it as a no-op
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MASK_W-1:0] fired_mask;
    logic [TIME_W-1:0] milliseconds;
    logic [TIME_W-1:0] microseconds;
  } timer_result_t;

  logic clk;
  logic rst;

  mcot_req_if req_ch ();
  mcot_rsp_if rsp_ch ();

  multi_channel_oneshot_timer_unit #(
    .CHANNELS       (CHANNELS),
    .SUBTICKS_PER_MS(SUBTICKS_PER_MS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Timer state as the block should hold it
  logic [TIME_W-1:0]   model_ms;
  logic [PERIOD_W-1:0] model_left [CHANNELS];
  logic                model_armed [CHANNELS];

  timer_result_t pending_results[$];

  int send_idle_pct;
  int stall_pct;
  int mismatches;
  int n_ticks, n_arms, n_cancels, n_unused, n_expiries;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Timer update for one accepted request; queues the expected response
  function automatic void predict_result(input logic [MODE_W-1:0] mode,
                                         input logic [CHAN_W-1:0] chan,
                                         input logic [PERIOD_W-1:0] period,
                                         input logic [SUB_W-1:0] sub);
    timer_result_t      exp;
    logic [MASK_W-1:0]  fired;
    longint unsigned    total_us;
    fired = '0;
    if (mode == MODE_TICK) begin
      n_ticks++;
      model_ms = model_ms + 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
        if (model_armed[c]) begin
          model_left[c] = model_left[c] - 1'b1;
          if (model_left[c] == '0) begin
            fired[c]       = 1'b1;
            model_armed[c] = 1'b0;
            n_expiries++;
          end
        end
      end
    end else if (mode == MODE_ARM) begin
      n_arms++;
      model_left[chan]  = period;
      model_armed[chan] = 1'b1;
    end else if (mode == MODE_CANCEL) begin
      n_cancels++;
      model_armed[chan] = 1'b0;
    end else begin
      n_unused++;
    end
    total_us = longint'(model_ms) * US_PER_MS
             + (longint'(sub) * US_PER_MS) / SUBTICKS_PER_MS;
    exp.fired_mask   = fired;
    exp.milliseconds = model_ms;
    exp.microseconds = total_us[TIME_W-1:0];
    pending_results.push_back(exp);
  endfunction

  // Present one request, with random idle cycles ahead of it, until accepted
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [CHAN_W-1:0] chan,
                              input logic [PERIOD_W-1:0] period,
                              input logic [SUB_W-1:0] sub);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= mode;
    req_ch.channel   <= chan;
    req_ch.period    <= period;
    req_ch.sub_count <= sub;
    do @(posedge clk); while (!req_ch.ready);
    predict_result(mode, chan, period, sub);
  endtask

  // Stop sending and hold off until every outstanding response is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic void report_field(input string field, input logic [TIME_W-1:0] exp_v,
                                       input logic [TIME_W-1:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("MISMATCH %s: expected 0x%08h, got 0x%08h", field, exp_v, act_v);
  endfunction

  // Response checker and receiver-side stall generator
  initial begin : response_checker
    timer_result_t exp;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("MISMATCH: response with nothing outstanding (ms 0x%08h)",
                     rsp_ch.milliseconds);
        end else begin
          exp = pending_results.pop_front();
          if (rsp_ch.fired_mask !== exp.fired_mask)
            report_field("fired_mask", TIME_W'(exp.fired_mask), TIME_W'(rsp_ch.fired_mask));
          if (rsp_ch.milliseconds !== exp.milliseconds)
            report_field("milliseconds", exp.milliseconds, rsp_ch.milliseconds);
          if (rsp_ch.microseconds !== exp.microseconds)
            report_field("microseconds", exp.microseconds, rsp_ch.microseconds);
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: too long with no handshake on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TIMEOUT: no handshake for %0d cycles, %0d responses outstanding",
             QUIET_LIMIT, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  // Tick, arm, cancel and the unused mode, with a simple expiry
  task automatic test_mode_basics();
    send_request(MODE_TICK, 2'd0, 32'd0, 14'd0);
    send_request(MODE_ARM, 2'd0, 32'd1, 14'd15999);
    send_request(MODE_TICK, 2'd0, 32'd0, 14'd16383);   // ch0 expires
    send_request(MODE_ARM, 2'd1, 32'd3, 14'd8000);
    send_request(MODE_CANCEL, 2'd1, 32'd0, 14'd1);
    send_request(MODE_TICK, 2'd2, 32'hFFFF_FFFF, 14'd16000);
    send_request(MODE_UNUSED, 2'd3, 32'hFFFF_FFFF, 14'd16000);
  endtask

  // Period and sub count extremes, including arm with zero period
  task automatic test_field_extremes();
    send_request(MODE_ARM, 2'd3, 32'hFFFF_FFFF, 14'h2AAA);
    send_request(MODE_ARM, 2'd2, 32'd0, 14'h1555);      // wraps, fires after 2^32 ticks
    send_request(MODE_TICK, 2'd1, 32'hAAAA_AAAA, 14'h3FFF);
    send_request(MODE_CANCEL, 2'd3, 32'h5555_5555, 14'd0);
    send_request(MODE_CANCEL, 2'd2, 32'd0, 14'd15999);
  endtask

  // Reload of an active channel, all channels firing together, cancel of idle channel
  task automatic test_special_cases();
    for (int c = 0; c < CHANNELS; c++)
      send_request(MODE_ARM, CHAN_W'(c), 32'd2, SUB_W'(c * 4000));
    send_request(MODE_TICK, 2'd0, 32'd0, 14'd123);
    send_request(MODE_ARM, 2'd1, 32'd1, 14'd456);
    send_request(MODE_TICK, 2'd0, 32'd0, 14'd789);      // all four fire
    send_request(MODE_CANCEL, 2'd0, 32'd0, 14'd1000);
    send_request(MODE_TICK, 2'd3, 32'd0, 14'd16001);
  endtask

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // Mostly ticks over armed channels with short periods, so expiries are frequent
  task automatic test_random_traffic(input int count, input int idle_pct, input int hold_pct);
    int pick;
    logic [MODE_W-1:0] mode;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 55)      mode = MODE_TICK;
      else if (pick < 82) mode = MODE_ARM;
      else if (pick < 95) mode = MODE_CANCEL;
      else                mode = MODE_UNUSED;
      send_request(mode, CHAN_W'($urandom_range(CHANNELS - 1)), pick_period(),
                   SUB_W'($urandom_range(16383)));
    end
    wait_drained();
  endtask

  // Main sequence
  initial begin
    mismatches    = 0;
    n_ticks       = 0;
    n_arms        = 0;
    n_cancels     = 0;
    n_unused      = 0;
    n_expiries    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    model_ms      = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      model_left[c]  = '0;
      model_armed[c] = 1'b0;
    end
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.mode      <= MODE_TICK;
    req_ch.channel   <= '0;
    req_ch.period    <= '0;
    req_ch.sub_count <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_mode_basics();
    test_field_extremes();
    test_special_cases();
    wait_drained();

    test_random_traffic(RANDOM_ITEMS, 0, 0);
    test_random_traffic(RANDOM_ITEMS, 68, 0);
    test_random_traffic(RANDOM_ITEMS, 0, 68);
    test_random_traffic(RANDOM_ITEMS, 24, 24);

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d ticks, %0d arms, %0d cancels, %0d unused-mode",
             n_ticks + n_arms + n_cancels + n_unused, n_ticks, n_arms, n_cancels, n_unused);
    $display("%0d channel expiries seen across four idle/stall mixes, %0d mismatches",
             n_expiries, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl/core
rtl/core/mcot_pkg.sv
rtl/core/mcot_if.sv
rtl/core/mcot_chan_bank.sv
rtl/core/mcot_time_base.sv
rtl/core/multi_channel_oneshot_timer_unit.sv
tb/tb.sv
